>>> design/d4wt_pkg.sv
// Package for the Daubechies-4 wavelet engine: item structs, opcodes, FSM states,
// Q1.15 filter taps. No dependencies.
package d4wt_pkg;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_RUN    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] REG_LENGTH  = 2'd0;
    localparam logic [1:0] REG_INVERSE = 2'd1;
    localparam logic [1:0] REG_LEVELS  = 2'd2;

    localparam logic signed [16:0] K0 = 17'sd15826;
    localparam logic signed [16:0] K1 = 17'sd27411;
    localparam logic signed [16:0] K2 = 17'sd7345;
    localparam logic signed [16:0] K3 = -17'sd4240;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         sample_index;
        logic signed [31:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               result_kind;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_CALC,
        ST_COPY,
        ST_NEXT,
        ST_DONE
    } state_t;

    // coefficient tap k of output row r (r=0 smooth/even, r=1 detail/odd)
    function automatic logic signed [16:0] coef(input logic inv, input logic r,
                                               input logic [1:0] k);
        logic signed [16:0] c;
        c = K0;
        if (!inv)
        begin
            unique case ({r, k})
                3'd0: c = K0;
                3'd1: c = K1;
                3'd2: c = K2;
                3'd3: c = K3;
                3'd4: c = K3;
                3'd5: c = -K2;
                3'd6: c = K1;
                default: c = -K0;
            endcase
        end
        else
        begin
            unique case ({r, k})
                3'd0: c = K2;
                3'd1: c = K1;
                3'd2: c = K0;
                3'd3: c = K3;
                3'd4: c = K3;
                3'd5: c = -K0;
                3'd6: c = K1;
                default: c = -K2;
            endcase
        end
        return c;
    endfunction

endpackage

>>> design/d4wt_mac.sv
// Multiply-accumulate unit: one tap product a cycle on prod_en, registered
// product, then accumulate; round and saturate the sum. Uses no package.
module d4wt_mac #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         clear,
    input  logic                         prod_en,
    input  logic                         acc_en,
    input  logic signed [16:0]           coef,
    input  logic signed [DATA_WIDTH-1:0] sample,
    output logic signed [DATA_WIDTH-1:0] result
);
    localparam int PW = DATA_WIDTH + 17;
    localparam int AW = PW + 3;

    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] rnd;
    logic signed [AW-16:0] q;
    logic signed [AW-16:0] hi;
    logic signed [AW-16:0] lo;

    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            prod_reg <= coef * sample;
        end
        if (clear)
        begin
            acc_reg <= AW'(16384);
        end
        else if (acc_en)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    always_comb
    begin
        rnd = acc_reg;
        q   = rnd[AW-1:15];
        hi  = (AW-15)'({1'b0, {(DATA_WIDTH-1){1'b1}}});
        lo  = ~hi;
        if (q > hi)
        begin
            result = hi[DATA_WIDTH-1:0];
        end
        else if (q < lo)
        begin
            result = lo[DATA_WIDTH-1:0];
        end
        else
        begin
            result = q[DATA_WIDTH-1:0];
        end
    end
endmodule

>>> design/d4wt_store.sv
// Sample and work memories with registered reads. Does not use d4wt_pkg;
// no package items needed here.
module d4wt_store #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          s_we,
    input  logic [AW-1:0] s_waddr,
    input  logic [DW-1:0] s_wdata,
    input  logic [AW-1:0] s_raddr,
    output logic [DW-1:0] s_rdata,
    input  logic          w_we,
    input  logic [AW-1:0] w_waddr,
    input  logic [DW-1:0] w_wdata,
    input  logic [AW-1:0] w_raddr,
    output logic [DW-1:0] w_rdata
);
    logic [DW-1:0] smem [2**AW];
    logic [DW-1:0] wmem [2**AW];

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[s_waddr] <= s_wdata;
        end
        s_rdata <= smem[s_raddr];
        if (w_we)
        begin
            wmem[w_waddr] <= w_wdata;
        end
        w_rdata <= wmem[w_raddr];
    end
endmodule

>>> design/daubechies4_wavelet_transform.sv
// Daubechies-4 pyramid wavelet engine, top level: control FSM, config registers.
// Depends on d4wt_pkg, d4wt_store, d4wt_mac.
//
// The block holds a MAX_LENGTH-entry sample memory and an equal scratch memory.
// A write item gives no result. A read item in range is read from the sample
// memory, passes through the READ state, where the input stalls, and then
// presents its data. A run item executes the configured pyramid levels in place:
// for every output the four input taps are read from the sample memory one at
// a time and multiplied by one shared 17x DATA_WIDTH multiplier; each tap takes
// a FETCH and a CALC step, then one step finishes the sum and one writes it to
// the scratch memory. After each level, the scratch entries are copied back to
// the sample memory (read, then write). The taps are read through the single
// read port of the sample memory. Run ends with a done result (value zero).
// Samples saturate to DATA_WIDTH on write and to 32 bits on read. No clearing
// pass: entries are undefined until written. Config is written over APB at
// byte addresses 0, 4, 8.
module daubechies4_wavelet_transform #(
    parameter int MAX_LENGTH = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  d4wt_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output d4wt_pkg::out_item_t         out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int AW     = $clog2(MAX_LENGTH);
    localparam int MAXLOG = $clog2(MAX_LENGTH + 1) - 1;   // floor(log2)
    localparam longint WR_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam longint WR_LO = -WR_HI - 64'sd1;

    logic [3:0] len_reg;
    logic       inv_reg;
    logic [3:0] lvl_reg;

    d4wt_pkg::state_t state_reg, state_next;
    logic [AW-1:0] i_reg, i_next;      // pair index / copy index
    logic [2:0]    t_reg, t_next;      // tap step within a pair
    logic [3:0]    k_reg, k_next;      // level counter
    logic [3:0]    nlv_reg, nlv_next;
    logic [AW:0]   m_reg, m_next;      // current level length
    logic          ov_reg, ov_next;
    d4wt_pkg::out_item_t ob_reg, ob_next;

    // store ports
    logic                  s_we, w_we;
    logic [AW-1:0]         s_waddr, s_raddr, w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0] s_wdata, s_rdata, w_wdata, w_rdata;

    logic                  mclear, mprod, macc;
    logic signed [16:0]    mcoef;
    logic signed [DATA_WIDTH-1:0] mres;
    logic signed [DATA_WIDTH-1:0] wr_sat;

    logic       in_acc;
    logic [3:0] lg_eff;
    logic [3:0] lv_eff;
    logic [AW-1:0] h, tap_addr, pidx;
    logic [1:0] tk;
    logic       trow;
    logic       cfg_we;

    d4wt_store #(.AW(AW), .DW(DATA_WIDTH)) u_store (
        .clk(clk),
        .s_we(s_we), .s_waddr(s_waddr), .s_wdata(s_wdata),
        .s_raddr(s_raddr), .s_rdata(s_rdata),
        .w_we(w_we), .w_waddr(w_waddr), .w_wdata(w_wdata),
        .w_raddr(w_raddr), .w_rdata(w_rdata)
    );

    d4wt_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
        .clk(clk), .clear(mclear), .prod_en(mprod), .acc_en(macc),
        .coef(mcoef), .sample($signed(s_rdata)), .result(mres)
    );

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            d4wt_pkg::REG_LENGTH:  prdata = {28'd0, len_reg};
            d4wt_pkg::REG_INVERSE: prdata = {31'd0, inv_reg};
            d4wt_pkg::REG_LEVELS:  prdata = {28'd0, lvl_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 4'd10;
            inv_reg <= 1'b0;
            lvl_reg <= 4'd9;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                d4wt_pkg::REG_LENGTH:  len_reg <= pwdata[3:0];
                d4wt_pkg::REG_INVERSE: inv_reg <= pwdata[0];
                d4wt_pkg::REG_LEVELS:  lvl_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lg_eff = len_reg;
        if (lg_eff < 4'd2)
        begin
            lg_eff = 4'd2;
        end
        if (5'(lg_eff) > 5'(MAXLOG))
        begin
            lg_eff = 4'(MAXLOG);
        end
        lv_eff = (lvl_reg > lg_eff - 4'd1) ? lg_eff - 4'd1 : lvl_reg;
    end

    // write data saturated to the store width
    always_comb
    begin
        wr_sat = DATA_WIDTH'(in_item.sample_value);
        if (longint'(in_item.sample_value) > WR_HI)
        begin
            wr_sat = DATA_WIDTH'(WR_HI);
        end
        else if (longint'(in_item.sample_value) < WR_LO)
        begin
            wr_sat = DATA_WIDTH'(WR_LO);
        end
    end

    // tap schedule: steps 0..3 row 0, steps 4..7 row 1
    assign tk   = t_reg[1:0];
    assign trow = t_reg[2];
    assign h    = m_reg[AW:1];
    assign pidx = (i_reg == '0) ? h - AW'(1) : i_reg - AW'(1);

    always_comb
    begin
        logic [AW:0] j;
        j = {i_reg, 1'b0} + (AW+1)'(tk);
        if (j >= m_reg)
        begin
            j = j - m_reg;
        end
        if (!inv_reg)
        begin
            tap_addr = j[AW-1:0];
        end
        else
        begin
            unique case (tk)
                2'd0: tap_addr = pidx;
                2'd1: tap_addr = pidx + h;
                2'd2: tap_addr = i_reg;
                default: tap_addr = i_reg + h;
            endcase
        end
    end

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != d4wt_pkg::ST_IDLE) || (ov_reg && out_stall);
    assign out_valid = ov_reg;
    assign out_item  = ob_reg;

    always_comb
    begin
        logic signed [31:0] rv;
        state_next = state_reg;
        i_next = i_reg;
        t_next = t_reg;
        k_next = k_reg;
        nlv_next = nlv_reg;
        m_next = m_reg;
        ov_next = ov_reg && out_stall;
        ob_next = ob_reg;
        s_we = 1'b0;
        s_waddr = AW'(in_item.sample_index);
        s_wdata = wr_sat;
        s_raddr = AW'(in_item.sample_index);
        w_we = 1'b0;
        w_waddr = i_reg;
        w_wdata = mres;
        w_raddr = i_reg;
        mclear = 1'b0;
        mprod = 1'b0;
        macc = 1'b0;
        mcoef = d4wt_pkg::coef(inv_reg, trow, tk);
        rv = 32'sd0;
        unique case (state_reg)
            d4wt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_item.opcode)
                        d4wt_pkg::OP_WRITE:
                        begin
                            s_we = (32'(in_item.sample_index) < 32'(MAX_LENGTH));
                        end
                        d4wt_pkg::OP_RUN:
                        begin
                            i_next = '0;
                            t_next = '0;
                            k_next = '0;
                            nlv_next = lv_eff;
                            m_next = inv_reg ? (AW+1)'(4) : (AW+1)'(1) << lg_eff;
                            state_next = d4wt_pkg::ST_NEXT;
                        end
                        d4wt_pkg::OP_READ:
                        begin
                            state_next = d4wt_pkg::ST_READ;
                            if (32'(in_item.sample_index) >= 32'(MAX_LENGTH))
                            begin
                                state_next = d4wt_pkg::ST_IDLE;
                                ov_next = 1'b1;
                                ob_next = '{result_value: 32'sd0,
                                            result_kind: d4wt_pkg::KIND_DATA};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            d4wt_pkg::ST_READ:
            begin
                if (DATA_WIDTH > 32)
                begin
                    if ($signed(s_rdata) > DATA_WIDTH'(32'sh7fffffff))
                    begin
                        rv = 32'sh7fffffff;
                    end
                    else if ($signed(s_rdata) < -$signed(DATA_WIDTH'(33'sh80000000)))
                    begin
                        rv = 32'sh80000000;
                    end
                    else
                    begin
                        rv = 32'(s_rdata);
                    end
                end
                else
                begin
                    rv = 32'($signed(s_rdata));
                end
                ov_next = 1'b1;
                ob_next = '{result_value: rv, result_kind: d4wt_pkg::KIND_DATA};
                state_next = d4wt_pkg::ST_IDLE;
            end
            d4wt_pkg::ST_NEXT:
            begin
                if (k_reg == nlv_reg)
                begin
                    state_next = d4wt_pkg::ST_DONE;
                end
                else
                begin
                    i_next = '0;
                    t_next = '0;
                    state_next = d4wt_pkg::ST_FETCH;
                end
            end
            d4wt_pkg::ST_FETCH:
            begin
                // issue the read for tap tk of the current row; clear the mac on tap 0
                s_raddr = tap_addr;
                mclear = (tk == 2'd0);
                state_next = d4wt_pkg::ST_CALC;
            end
            d4wt_pkg::ST_CALC:
            begin
                // data for tap t is here: multiply; accumulate previous product
                mcoef = d4wt_pkg::coef(inv_reg, trow, tk);
                mprod = 1'b1;
                macc  = (tk != 2'd0);
                if (tk != 2'd3)
                begin
                    t_next = t_reg + 3'd1;
                    state_next = d4wt_pkg::ST_FETCH;
                end
                else
                begin
                    state_next = d4wt_pkg::ST_COPY;
                end
            end
            d4wt_pkg::ST_COPY:
            begin
                // tk==3 accumulates the last product, tk==2 writes it; tk 0 and 1 copy back
                if (tk == 2'd3)
                begin
                    macc = 1'b1;
                    t_next = {trow, 2'b10};
                    state_next = d4wt_pkg::ST_COPY;
                end
                else if (tk == 2'd2)
                begin
                    w_we = 1'b1;
                    if (!inv_reg)
                    begin
                        w_waddr = trow ? i_reg + h : i_reg;
                    end
                    else
                    begin
                        w_waddr = {i_reg[AW-2:0], trow};
                    end
                    if (!trow)
                    begin
                        t_next = 3'd4;
                        state_next = d4wt_pkg::ST_FETCH;
                    end
                    else if (i_reg == h - AW'(1))
                    begin
                        i_next = '0;
                        t_next = 3'd0;
                        w_raddr = '0;
                        state_next = d4wt_pkg::ST_COPY;
                    end
                    else
                    begin
                        i_next = i_reg + AW'(1);
                        t_next = 3'd0;
                        state_next = d4wt_pkg::ST_FETCH;
                    end
                end
                else if (tk == 2'd0)
                begin
                    // copy phase: read work[i], next cycle write sample[i]
                    w_raddr = i_reg;
                    t_next = 3'd1;
                end
                else
                begin
                    s_we = 1'b1;
                    s_waddr = i_reg;
                    s_wdata = w_rdata;
                    t_next = 3'd0;
                    if ((AW+1)'(i_reg) == m_reg - (AW+1)'(1))
                    begin
                        k_next = k_reg + 4'd1;
                        m_next = inv_reg ? {m_reg[AW-1:0], 1'b0} : {1'b0, m_reg[AW:1]};
                        state_next = d4wt_pkg::ST_NEXT;
                    end
                    else
                    begin
                        i_next = i_reg + AW'(1);
                    end
                end
            end
            d4wt_pkg::ST_DONE:
            begin
                if (!(ov_reg && out_stall))
                begin
                    ov_next = 1'b1;
                    ob_next = '{result_value: 32'sd0, result_kind: d4wt_pkg::KIND_DONE};
                    state_next = d4wt_pkg::ST_IDLE;
                end
            end
            default: state_next = d4wt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= d4wt_pkg::ST_IDLE;
            ov_reg <= 1'b0;
            i_reg <= '0;
            t_reg <= '0;
            k_reg <= '0;
            nlv_reg <= '0;
            m_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            i_reg <= i_next;
            t_reg <= t_next;
            k_reg <= k_next;
            nlv_reg <= nlv_next;
            m_reg <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != d4wt_pkg::ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == d4wt_pkg::ST_DONE && !(ov_reg && out_stall)) |=>
        (out_valid && out_item.result_kind == d4wt_pkg::KIND_DONE))
        else $error("done item missing");
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == d4wt_pkg::ST_READ) |=> out_valid)
        else $error("read data missing");
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != d4wt_pkg::ST_IDLE) |-> (k_reg <= nlv_reg))
        else $error("level counter overran");
`endif
endmodule
